// ----- src/wer_pkg.sv -----
// ----------------------------------------------------------------------------
// wer_pkg - windowed event rate meter shared types and constants
// Payload structs of the event, command and rate channels, register indexes,
// display mode codes and the fixed arithmetic constants.
// ----------------------------------------------------------------------------
package wer_pkg;

	// Configuration register indexes
	localparam int CFG_IDX_W = 1;
	localparam logic [CFG_IDX_W-1:0] REG_DISPLAY_MODE = 1'd0;
	localparam logic [CFG_IDX_W-1:0] REG_SCREEN_HERTZ = 1'd1;
	localparam int CFG_DATA_W = 8;

	// Display mode codes
	localparam logic [2:0] MODE_OFF     = 3'd0;
	localparam logic [2:0] MODE_VIDEO   = 3'd1;
	localparam logic [2:0] MODE_LIST    = 3'd2;
	localparam logic [2:0] MODE_BOTH    = 3'd3;
	localparam logic [2:0] MODE_PERCENT = 3'd4;

	// Event channel codes
	localparam logic CH_VIDEO = 1'b0;
	localparam logic CH_LIST  = 1'b1;

	// Sampling: every 8th video event, every 4th list event
	localparam int VIDEO_SHIFT = 3;
	localparam int LIST_SHIFT  = 2;
	localparam logic [31:0] VIDEO_MASK = 32'd7;
	localparam logic [31:0] LIST_MASK  = 32'd3;

	localparam int MS_PER_S = 1000;
	localparam logic [7:0] DEFAULT_HZ = 8'd60;
	localparam logic [23:0] RATE_MAX = 24'hFF_FFFF;
	localparam logic [15:0] PCT_MAX = 16'hFFFF;

	// Input event
	typedef struct packed {
		logic        opcode;
		logic [31:0] timestamp_ms;
	} evt_t;

	// Result item
	typedef struct packed {
		logic        channel;
		logic        rate_valid;
		logic [23:0] rate_q8;
		logic [15:0] percent_tenths;
	} rate_t;

	// Sample command from the front to the back
	typedef struct packed {
		logic        channel;
		logic        fill;      // window filled, rate is meaningful
		logic        pct;       // give percent of screen hertz
		logic        restart;   // event count wrapped, ring slot restarts at zero
		logic [31:0] interval;
	} cmd_t;

endpackage

// ----- src/wer_stream_if.sv -----
// ----------------------------------------------------------------------------
// wer_stream_if - valid/ready stream channel
// Carries one payload of type data_t per transfer.
// ----------------------------------------------------------------------------
interface wer_stream_if #(
	parameter type data_t = logic
);
	logic  valid;
	logic  ready;
	data_t data;

	modport source (output valid, output data, input ready);
	modport sink (input valid, input data, output ready);
endinterface

// ----- src/wer_front.sv -----
// ----------------------------------------------------------------------------
// wer_front - event classifier
// Filters events by display mode, counts them per channel, and on each
// sample event issues a command with the elapsed interval to the back end.
// ----------------------------------------------------------------------------
module wer_front
	import wer_pkg::*;
#(
	parameter int WINDOW = 8
) (
	input  logic clk,
	input  logic arst_n,
	input  logic clear,
	input  logic [2:0] mode,
	wer_stream_if.sink   events,
	wer_stream_if.source cmd
);

	localparam logic [31:0] VIDEO_SPAN = 32'(WINDOW << VIDEO_SHIFT);
	localparam logic [31:0] LIST_SPAN  = 32'(WINDOW << LIST_SHIFT);

	logic [31:0] count_q [2];
	logic [31:0] last_q  [2];

	logic        op;
	logic        en;
	logic [31:0] cnt;
	logic [31:0] mask;
	logic [31:0] span;
	logic        sample;
	logic        take;

	// Decode channel enable from the display mode
	always_comb begin
		op = events.data.opcode;
		unique case (mode)
			MODE_VIDEO, MODE_PERCENT: en = (op == CH_VIDEO);
			MODE_LIST:                en = (op == CH_LIST);
			MODE_BOTH:                en = 1'b1;
			default:                  en = 1'b0;
		endcase
		cnt    = count_q[op];
		mask   = (op == CH_LIST) ? LIST_MASK : VIDEO_MASK;
		span   = (op == CH_LIST) ? LIST_SPAN : VIDEO_SPAN;
		sample = ((cnt & mask) == 32'd0);
	end

	// Events pass only while the command queue has room
	assign events.ready = cmd.ready;
	assign take         = events.valid && events.ready && en;

	assign cmd.valid            = events.valid && en && sample;
	assign cmd.data.channel     = op;
	assign cmd.data.fill        = (cnt > span);
	assign cmd.data.pct         = (op == CH_VIDEO) && (mode == MODE_PERCENT);
	assign cmd.data.restart     = (cnt == 32'd0);
	assign cmd.data.interval    = events.data.timestamp_ms - last_q[op];

	// Advance the count, hold the sample time
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q <= '{default: '0};
			last_q  <= '{default: '0};
		end else if (clear) begin
			count_q <= '{default: '0};
			last_q  <= '{default: '0};
		end else if (take) begin
			count_q[op] <= cnt + 32'd1;
			if (sample) begin
				last_q[op] <= events.data.timestamp_ms;
			end
		end
	end

endmodule

// ----- src/wer_cmd_fifo.sv -----
// ----------------------------------------------------------------------------
// wer_cmd_fifo - two-entry command queue
// Decouples the event classifier from the rate computation.
// ----------------------------------------------------------------------------
module wer_cmd_fifo
	import wer_pkg::*;
(
	input  logic clk,
	input  logic arst_n,
	input  logic clear,
	wer_stream_if.sink   push,
	wer_stream_if.source pop
);

	localparam int DEPTH = 2;
	localparam int PTR_W = $clog2(DEPTH);

	cmd_t             mem_q [DEPTH];
	logic [PTR_W-1:0] wr_ptr_q;
	logic [PTR_W-1:0] rd_ptr_q;
	logic [PTR_W:0]   fill_q;
	logic             do_push;
	logic             do_pop;

	assign push.ready = (fill_q != (PTR_W+1)'(DEPTH));
	assign pop.valid  = (fill_q != '0);
	assign pop.data   = mem_q[rd_ptr_q];
	assign do_push    = push.valid && push.ready;
	assign do_pop     = pop.valid && pop.ready;

	// Track pointers and occupancy
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			fill_q   <= '0;
		end else if (clear) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			fill_q   <= '0;
		end else begin
			if (do_push) begin
				wr_ptr_q <= wr_ptr_q + PTR_W'(1);
			end
			if (do_pop) begin
				rd_ptr_q <= rd_ptr_q + PTR_W'(1);
			end
			if (do_push && !do_pop) begin
				fill_q <= fill_q + (PTR_W+1)'(1);
			end else if (do_pop && !do_push) begin
				fill_q <= fill_q - (PTR_W+1)'(1);
			end
		end
	end

	// Store entries
	always_ff @(posedge clk) begin
		if (do_push) begin
			mem_q[wr_ptr_q] <= push.data;
		end
	end

endmodule

// ----- src/wer_back.sv -----
// ----------------------------------------------------------------------------
// wer_back - interval ring and rate computation
// Keeps the interval rings and their running sums, then divides the window
// span by the sum with a shared bit-serial divider for rate and percent.
// ----------------------------------------------------------------------------
module wer_back
	import wer_pkg::*;
#(
	parameter int WINDOW = 8
) (
	input  logic clk,
	input  logic arst_n,
	input  logic clear,
	input  logic [7:0] hz,
	wer_stream_if.sink   cmd,
	wer_stream_if.source rates
);

	localparam int IDX_W   = $clog2(WINDOW);
	localparam int ADDR_W  = IDX_W + 1;
	localparam int ENTRIES = 2 ** ADDR_W;
	localparam int SUM_W   = 32 + $clog2(WINDOW);
	localparam int DEN_W   = SUM_W + 8;
	localparam int NUM_MAX = (WINDOW << VIDEO_SHIFT) * MS_PER_S * 1000;
	localparam int NUM_W   = $clog2(NUM_MAX + 1);
	localparam int CNT_W   = $clog2(NUM_W);
	localparam int EXT_W   = NUM_W + 24;
	localparam logic [NUM_W-1:0] NUM_RATE_V =
		NUM_W'((WINDOW << VIDEO_SHIFT) * MS_PER_S * 256);
	localparam logic [NUM_W-1:0] NUM_RATE_L =
		NUM_W'((WINDOW << LIST_SHIFT) * MS_PER_S * 256);
	localparam logic [NUM_W-1:0] NUM_PCT_V = NUM_W'(NUM_MAX);
	localparam logic [IDX_W-1:0] IDX_LAST = IDX_W'(WINDOW - 1);

	typedef enum logic [2:0] {
		S_IDLE,
		S_READ,
		S_SUM,
		S_DIV,
		S_MUL,
		S_OUT
	} state_t;

	state_t             state_q;
	cmd_t               cmd_q;
	logic [IDX_W-1:0]   idx_q;
	logic [IDX_W-1:0]   ptr_q [2];
	logic [SUM_W-1:0]   sum_q [2];
	logic [SUM_W-1:0]   acc_q;
	logic [ENTRIES-1:0] vld_q;
	logic               old_vld_q;
	logic [31:0]        ring_mem [ENTRIES];
	logic [31:0]        rd_q;
	logic [DEN_W-1:0]   den_q;
	logic [DEN_W-1:0]   rem_q;
	logic [NUM_W-1:0]   num_q;
	logic [CNT_W-1:0]   cnt_q;
	logic               div_pct_q;
	rate_t              res_q;

	logic [IDX_W-1:0]   idx_sel;
	logic [ADDR_W-1:0]  rd_addr;
	logic [ADDR_W-1:0]  wr_addr;
	logic [31:0]        old_val;
	logic [SUM_W-1:0]   sum_new;
	logic [DEN_W:0]     trial;
	logic               qbit;
	logic [DEN_W-1:0]   rem_next;
	logic [NUM_W-1:0]   quo;
	logic [EXT_W-1:0]   quo_ext;
	logic               wr_en;

	assign idx_sel = cmd.data.restart ? '0 : ptr_q[cmd.data.channel];
	assign rd_addr = {cmd.data.channel, idx_sel};
	assign wr_addr = {cmd_q.channel, idx_q};
	assign wr_en   = (state_q == S_READ);
	assign old_val = old_vld_q ? rd_q : 32'd0;
	assign sum_new = sum_q[cmd_q.channel] - SUM_W'(old_val) + SUM_W'(cmd_q.interval);

	// One restoring divide step: shift in the next numerator bit
	assign trial    = {rem_q, num_q[NUM_W-1]};
	assign qbit     = (trial >= {1'b0, den_q});
	assign rem_next = qbit ? DEN_W'(trial - {1'b0, den_q}) : trial[DEN_W-1:0];
	assign quo      = {num_q[NUM_W-2:0], qbit};
	assign quo_ext  = EXT_W'(quo);

	assign cmd.ready  = (state_q == S_IDLE);
	assign rates.valid = (state_q == S_OUT);
	assign rates.data  = res_q;

	// Ring storage, read data registered
	always_ff @(posedge clk) begin
		if (wr_en) begin
			ring_mem[wr_addr] <= cmd_q.interval;
		end
		rd_q <= ring_mem[rd_addr];
	end

	// Sequence a sample: read old slot, update sum, divide, present result
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q   <= S_IDLE;
			vld_q     <= '0;
			ptr_q     <= '{default: '0};
			sum_q     <= '{default: '0};
			old_vld_q <= 1'b0;
			div_pct_q <= 1'b0;
			cnt_q     <= '0;
			cmd_q     <= '0;
			idx_q     <= '0;
			acc_q     <= '0;
			den_q     <= '0;
			rem_q     <= '0;
			num_q     <= '0;
			res_q     <= '0;
		end else if (clear) begin
			state_q   <= S_IDLE;
			vld_q     <= '0;
			ptr_q     <= '{default: '0};
			sum_q     <= '{default: '0};
			old_vld_q <= 1'b0;
			div_pct_q <= 1'b0;
			cnt_q     <= '0;
		end else begin
			unique case (state_q)
				S_IDLE: begin
					if (cmd.valid) begin
						cmd_q     <= cmd.data;
						idx_q     <= idx_sel;
						old_vld_q <= vld_q[rd_addr];
						state_q   <= S_READ;
					end
				end
				S_READ: begin
					sum_q[cmd_q.channel] <= sum_new;
					acc_q                <= sum_new;
					vld_q[wr_addr]       <= 1'b1;
					ptr_q[cmd_q.channel] <= (idx_q == IDX_LAST) ? '0 : idx_q + IDX_W'(1);
					state_q              <= S_SUM;
				end
				S_SUM: begin
					res_q.channel    <= cmd_q.channel;
					res_q.rate_valid <= cmd_q.fill;
					if (!cmd_q.fill) begin
						res_q.rate_q8        <= '0;
						res_q.percent_tenths <= '0;
						state_q              <= S_OUT;
					end else if (acc_q == '0) begin
						res_q.rate_q8        <= RATE_MAX;
						res_q.percent_tenths <= cmd_q.pct ? PCT_MAX : '0;
						state_q              <= S_OUT;
					end else begin
						res_q.rate_q8        <= '0;
						res_q.percent_tenths <= '0;
						den_q     <= DEN_W'(acc_q);
						num_q     <= (cmd_q.channel == CH_LIST) ? NUM_RATE_L : NUM_RATE_V;
						rem_q     <= '0;
						cnt_q     <= '0;
						div_pct_q <= 1'b0;
						state_q   <= S_DIV;
					end
				end
				S_DIV: begin
					rem_q <= rem_next;
					num_q <= quo;
					cnt_q <= cnt_q + CNT_W'(1);
					if (cnt_q == CNT_W'(NUM_W - 1)) begin
						if (!div_pct_q) begin
							res_q.rate_q8 <= (quo_ext > EXT_W'(RATE_MAX)) ?
								RATE_MAX : quo_ext[23:0];
							state_q <= cmd_q.pct ? S_MUL : S_OUT;
						end else begin
							res_q.percent_tenths <= (quo_ext > EXT_W'(PCT_MAX)) ?
								PCT_MAX : quo_ext[15:0];
							state_q <= S_OUT;
						end
					end
				end
				S_MUL: begin
					den_q     <= DEN_W'(acc_q * hz);
					num_q     <= NUM_PCT_V;
					rem_q     <= '0;
					cnt_q     <= '0;
					div_pct_q <= 1'b1;
					state_q   <= S_DIV;
				end
				S_OUT: begin
					if (rates.ready) begin
						state_q <= S_IDLE;
					end
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

`ifndef SYNTHESIS
	// Ring write pointers stay inside the window
	a_ptr_range: assert property (@(posedge clk) disable iff (!arst_n)
		(ptr_q[0] <= IDX_LAST) && (ptr_q[1] <= IDX_LAST))
		else $error("ring pointer beyond window");

	// Divider remainder stays below the divisor
	a_rem_bound: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_DIV) |-> (rem_q < den_q))
		else $error("divider remainder not below divisor");

	// An unfilled window reports zero rate and percent
	a_unfilled_zero: assert property (@(posedge clk) disable iff (!arst_n)
		(rates.valid && !rates.data.rate_valid) |->
		(rates.data.rate_q8 == '0) && (rates.data.percent_tenths == '0))
		else $error("unfilled window with nonzero rate");

	// Percent only ever appears on the video channel
	a_pct_video: assert property (@(posedge clk) disable iff (!arst_n)
		(rates.valid && (rates.data.percent_tenths != '0)) |->
		(rates.data.channel == CH_VIDEO))
		else $error("percent on list channel");

	// A taken command always moves on to the ring read
	a_cmd_read: assert property (@(posedge clk) disable iff (!arst_n || clear)
		(cmd.valid && cmd.ready) |=> (state_q == S_READ))
		else $error("command transfer without ring read");
`endif

endmodule

// ----- src/windowed_event_rate_meter.sv -----
// ----------------------------------------------------------------------------
// windowed_event_rate_meter - two-channel windowed event rate meter
// Measures video tick and display list rates over a window of sampled
// intervals, in Q8 events per second and percent of screen refresh.
//
//   channel   dir  payload   transfer
//   events    in   evt_t     valid && ready
//   rates     out  rate_t    valid && ready
//   cfg       in   index+8b  cfg_we
//
// A sample event is processed by a bit-serial divider (NUM_W = 29 at WINDOW 64),
// run once for rate and again for percent when percent mode is selected.
// Other events are taken whenever the command queue has room; a two-entry command
// queue lets events keep arriving while a result waits on the rates channel.
// Reset and any configuration write clear counts, rings and sums at once.
// ----------------------------------------------------------------------------
module windowed_event_rate_meter
	import wer_pkg::*;
#(
	parameter int WINDOW = 8
) (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  cfg_we,
	input  logic [CFG_IDX_W-1:0]  cfg_index,
	input  logic [CFG_DATA_W-1:0] cfg_data,
	wer_stream_if.sink            events,
	wer_stream_if.source          rates
);

	logic [2:0] mode_q;
	logic [7:0] hz_q;
	logic       clear;

	wer_stream_if #(.data_t(cmd_t)) cmd_push ();
	wer_stream_if #(.data_t(cmd_t)) cmd_pop ();

	assign clear = cfg_we;

	// Hold configuration registers; a zero refresh rate falls back to default
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mode_q <= MODE_VIDEO;
			hz_q   <= DEFAULT_HZ;
		end else if (cfg_we) begin
			unique case (cfg_index)
				REG_DISPLAY_MODE: mode_q <= cfg_data[2:0];
				REG_SCREEN_HERTZ: hz_q <= (cfg_data == '0) ? DEFAULT_HZ : cfg_data;
				default: ;
			endcase
		end
	end

	wer_front #(.WINDOW(WINDOW)) u_front (
		.clk    (clk),
		.arst_n (arst_n),
		.clear  (clear),
		.mode   (mode_q),
		.events (events),
		.cmd    (cmd_push)
	);

	wer_cmd_fifo u_fifo (
		.clk    (clk),
		.arst_n (arst_n),
		.clear  (clear),
		.push   (cmd_push),
		.pop    (cmd_pop)
	);

	wer_back #(.WINDOW(WINDOW)) u_back (
		.clk    (clk),
		.arst_n (arst_n),
		.clear  (clear),
		.hz     (hz_q),
		.cmd    (cmd_pop),
		.rates  (rates)
	);

endmodule
